@@ rtl/cft_pkg.sv @@
// ----------------------------------------------------------------------------
// cft_pkg: shared types and constants for the continued fraction tangent
// fixed-point widths, saturation limits and the divider request/status records
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int X_W     = 32;   // angle magnitude width
  localparam int TERMS_W = 4;    // term count width
  localparam int Q_W     = 64;   // q32.32 word width
  localparam int DVD_W   = 72;   // left-aligned dividend width
  localparam int CNT_W   = 7;    // divider iteration counter width

  // dividend bit counts: x*x (63 bits) << 8, and |x| (32 bits) << 36
  localparam logic [CNT_W-1:0] INNER_BITS = 7'd71;
  localparam logic [CNT_W-1:0] FINAL_BITS = 7'd68;

  localparam logic [Q_W-1:0] POS_LIMIT = 64'h7fff_ffff_ffff_ffff;
  localparam logic [Q_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [Q_W-1:0] ONE_Q32   = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;   // left-aligned, msb first
    logic [CNT_W-1:0] count;      // number of quotient bits to develop
    logic [Q_W-1:0]   divisor;    // nonzero magnitude
    logic             neg_limit;  // cap at 2^63 instead of 2^63-1
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] mag;
    logic           sat;
  } div_rsp_t;

endpackage

@@ rtl/cft_div.sv @@
// ----------------------------------------------------------------------------
// cft_div: bit-serial restoring divider with saturating quotient
// one quotient bit per cycle; the quotient magnitude is capped at a limit
// ----------------------------------------------------------------------------
module cft_div (
  input  logic              clk,
  input  logic              rst,
  input  cft_pkg::div_req_t req,
  output cft_pkg::div_rsp_t rsp
);

  logic [cft_pkg::DVD_W-1:0] dvd;
  logic [cft_pkg::DVD_W-1:0] quo;
  logic [cft_pkg::Q_W-1:0]   rem;
  logic [cft_pkg::Q_W-1:0]   den;
  logic [cft_pkg::CNT_W-1:0] cnt;
  logic                      neg_lim;
  logic                      run;
  logic                      done;

  logic [cft_pkg::Q_W:0]     trial;
  logic [cft_pkg::Q_W:0]     diff;
  logic                      ge;
  logic                      sat;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem, dvd[cft_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = !diff[cft_pkg::Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
      end else if (run && cnt == 7'd1) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      den     <= req.divisor;
      cnt     <= req.count;
      neg_lim <= req.neg_limit;
      rem     <= '0;
      quo     <= '0;
    end else if (run) begin
      dvd <= {dvd[cft_pkg::DVD_W-2:0], 1'b0};
      rem <= ge ? diff[cft_pkg::Q_W-1:0] : trial[cft_pkg::Q_W-1:0];
      quo <= {quo[cft_pkg::DVD_W-2:0], ge};
      cnt <= cnt - 7'd1;
    end
  end

  // over the limit: 2^63-1 for positive results, 2^63 for negative ones
  always_comb begin
    if (neg_lim) begin
      sat = (|quo[cft_pkg::DVD_W-1:cft_pkg::Q_W]) ||
            (quo[cft_pkg::Q_W-1] && (|quo[cft_pkg::Q_W-2:0]));
    end else begin
      sat = |quo[cft_pkg::DVD_W-1:cft_pkg::Q_W-1];
    end
  end

  always_comb begin
    rsp.busy = run;
    rsp.done = done;
    rsp.sat  = sat;
    if (sat) begin
      rsp.mag = neg_lim ? cft_pkg::NEG_LIMIT : cft_pkg::POS_LIMIT;
    end else begin
      rsp.mag = quo[cft_pkg::Q_W-1:0];
    end
  end

endmodule

@@ rtl/continued_fraction_tangent.sv @@
// ----------------------------------------------------------------------------
// continued_fraction_tangent: tan(x) by lambert's continued fraction
// done pulses when the result is ready, after a shift-add squarer and then
// one serial quotient per clamped term; a zero divisor skips it
// a new request is taken from the cycle of the done strobe on
// synchronous reset returns to idle with busy and done low
// ----------------------------------------------------------------------------
module continued_fraction_tangent #(
  parameter int MAX_TERMS = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] angle,
  input  logic        [3:0]  terms,
  output logic               busy,
  output logic               done,
  output logic signed [63:0] tangent,
  output logic               overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,   // serial square of |x|
    S_SUB,   // divisor = k - f, saturated
    S_MAG,   // divisor magnitude, launch the division
    S_WAIT   // wait for the quotient
  } state_t;

  state_t state;

  // request operands
  logic                        x_neg;
  logic [cft_pkg::X_W-1:0]     ax;
  logic [cft_pkg::Q_W-1:0]     prod;     // shift-add product, ends as x*x
  logic [4:0]                  mcnt;
  logic [cft_pkg::TERMS_W-1:0] idx;      // term index i, counts down to 1
  logic                        last;     // working on the final 1 - f term
  logic [cft_pkg::Q_W-1:0]     f;        // fraction, signed q32.32
  logic [cft_pkg::Q_W-1:0]     d;        // current divisor, signed q32.32

  // input conditioning
  logic [cft_pkg::X_W-1:0]     ax_in;
  logic [cft_pkg::TERMS_W-1:0] n_lo;
  logic [cft_pkg::TERMS_W-1:0] n_eff;

  // datapath
  logic [cft_pkg::X_W:0]       mul_sum;
  logic [cft_pkg::Q_W-1:0]     k_val;
  logic [cft_pkg::Q_W:0]       diff;
  logic [cft_pkg::Q_W-1:0]     d_sat;
  logic                        d_zero;
  logic [cft_pkg::Q_W-1:0]     d_mag;
  logic                        x_zero;
  logic                        q_neg;

  cft_pkg::div_req_t div_req;
  cft_pkg::div_rsp_t div_rsp;

  // |angle|; the most negative angle maps to 2^31, which still fits
  assign ax_in = angle[31] ? (~angle + 32'd1) : angle;

  // zero terms means one term, then clamp to the configured depth
  assign n_lo  = (terms == 4'd0) ? 4'd1 : terms;
  assign n_eff = (32'(n_lo) > MAX_TERMS) ? cft_pkg::TERMS_W'(MAX_TERMS) : n_lo;

  // one multiplier bit per cycle: add |x| to the upper half, shift right
  assign mul_sum = {1'b0, prod[cft_pkg::Q_W-1:cft_pkg::X_W]} +
                   {1'b0, (prod[0] ? ax : '0)};

  // k is (2i+1) in q32.32 for the inner terms, 1.0 for the final one
  assign k_val = last ? cft_pkg::ONE_Q32 : {27'd0, idx, 1'b1, 32'd0};

  // k - f can only overflow upward since k is small and nonnegative
  assign diff  = {1'b0, k_val} - {f[cft_pkg::Q_W-1], f};
  assign d_sat = (!diff[cft_pkg::Q_W] && diff[cft_pkg::Q_W-1]) ?
                 cft_pkg::POS_LIMIT : diff[cft_pkg::Q_W-1:0];

  assign d_zero = (d == '0);
  assign d_mag  = d[cft_pkg::Q_W-1] ? (~d + 64'd1) : d;
  assign x_zero = (ax == '0);

  // sign of the final quotient; a zero angle gives a plain zero
  assign q_neg = (x_neg != d[cft_pkg::Q_W-1]) && !x_zero;

  // divider launch: inner terms divide x*x << 8, the final term |x| << 36
  always_comb begin
    div_req.start     = (state == S_MAG) && !d_zero;
    div_req.divisor   = d_mag;
    div_req.neg_limit = last && q_neg;
    if (last) begin
      div_req.dividend = {ax, 40'd0};
      div_req.count    = cft_pkg::FINAL_BITS;
    end else begin
      div_req.dividend = {prod[62:0], 9'd0};
      div_req.count    = cft_pkg::INNER_BITS;
    end
  end

  cft_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            x_neg <= angle[31];
            ax    <= ax_in;
            prod  <= {32'd0, ax_in};
            mcnt  <= '0;
            idx   <= n_eff - 4'd1;
            last  <= (n_eff == 4'd1);
            f     <= '0;
            busy  <= 1'b1;
            state <= S_MUL;
          end
        end

        S_MUL: begin
          prod <= {mul_sum, prod[cft_pkg::X_W-1:1]};
          mcnt <= mcnt + 5'd1;
          if (mcnt == 5'd31) begin
            state <= S_SUB;
          end
        end

        S_SUB: begin
          d     <= d_sat;
          state <= S_MAG;
        end

        S_MAG: begin
          if (!d_zero) begin
            state <= S_WAIT;
          end else if (!last) begin
            // zero inner divisor pins the fraction at the positive limit
            f     <= cft_pkg::POS_LIMIT;
            state <= S_SUB;
            if (idx == 4'd1) begin
              last <= 1'b1;
            end else begin
              idx <= idx - 4'd1;
            end
          end else begin
            // zero final divisor: signed limit by the angle (zero for a zero angle), flag it
            overflow <= 1'b1;
            if (x_zero) begin
              tangent <= '0;
            end else begin
              tangent <= x_neg ? cft_pkg::NEG_LIMIT : cft_pkg::POS_LIMIT;
            end
            done  <= 1'b1;
            busy  <= 1'b0;
            state <= S_IDLE;
          end
        end

        S_WAIT: begin
          if (div_rsp.done) begin
            if (!last) begin
              // inner quotient takes the sign of the divisor
              f     <= d[cft_pkg::Q_W-1] ? (~div_rsp.mag + 64'd1) : div_rsp.mag;
              state <= S_SUB;
              if (idx == 4'd1) begin
                last <= 1'b1;
              end else begin
                idx <= idx - 4'd1;
              end
            end else begin
              tangent  <= q_neg ? (~div_rsp.mag + 64'd1) : div_rsp.mag;
              overflow <= div_rsp.sat;
              done     <= 1'b1;
              busy     <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end

        default: begin
          busy  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // an accepted request always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // each request produces one strobe, and done is never high twice in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // the divider is only launched when idle
  a_div_launch: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider launched while running");

  // a quotient only arrives while the sequencer is waiting for it
  a_div_return: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_WAIT))
    else $error("quotient returned outside the wait state");
`endif

endmodule
